@@ hdl/addressed_serial_frame_deframer_defines.svh @@
// assertion macros used by the deframer top module
`ifndef ADDRESSED_SERIAL_FRAME_DEFRAMER_DEFINES_SVH
`define ADDRESSED_SERIAL_FRAME_DEFRAMER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ASFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/asfd_pkg.sv @@
// types and constants of the addressed serial frame deframer
`default_nettype none

package asfd_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] MAX_FRAME_LEN = 8'd128;
    localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd2;
    localparam logic [BYTE_W-1:0] CHAR_COLON    = 8'd58;
    localparam logic [BYTE_W-1:0] CHAR_QMARK    = 8'd63;
    localparam logic [BYTE_W-1:0] CHAR_CR       = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_LF       = 8'd10;
    localparam logic [BYTE_W-1:0] ADDR_BCAST    = 8'd0;

    localparam logic [1:0] CFG_DEVICE_ADDRESS  = 2'd0;
    localparam logic [1:0] CFG_FORWARD_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_FORWARD_ADDRESS = 2'd2;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_INFO    = 2'd1,
        KIND_CTS     = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        MODE_START   = 5'b00001,
        MODE_ADDR    = 5'b00010,
        MODE_LEN     = 5'b00100,
        MODE_RECV    = 5'b01000,
        MODE_FOREIGN = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] device_address;
        logic              forward_enable;
        logic [BYTE_W-1:0] forward_address;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [BYTE_W-1:0] len;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/asfd_cfg_regs.sv @@
// configuration registers of the deframer
`default_nettype none

module asfd_cfg_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [asfd_pkg::BYTE_W-1:0] cfg_wdata,
    output asfd_pkg::cfg_t                   cfg
);

    asfd_pkg::cfg_t cfg_reg;
    asfd_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                asfd_pkg::CFG_DEVICE_ADDRESS:  cfg_next.device_address  = cfg_wdata;
                asfd_pkg::CFG_FORWARD_ENABLE:  cfg_next.forward_enable  = cfg_wdata[0];
                asfd_pkg::CFG_FORWARD_ADDRESS: cfg_next.forward_address = cfg_wdata;
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address  <= 8'd1;
            cfg_reg.forward_enable  <= 1'b0;
            cfg_reg.forward_address <= 8'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hdl/asfd_in_stage.sv @@
// input register that holds one received byte until the parser takes it
`default_nettype none

module asfd_in_stage (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output wire logic                        s_ready,
    input  wire logic [asfd_pkg::BYTE_W-1:0] s_rx_byte,
    input  wire logic                        advance,
    output wire logic                        in_valid,
    output wire logic [asfd_pkg::BYTE_W-1:0] in_byte
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [asfd_pkg::BYTE_W-1:0] byte_reg;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

`default_nettype wire

@@ hdl/asfd_parser.sv @@
// frame parse state and single-pass next-state and event logic
`default_nettype none

module asfd_parser (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire asfd_pkg::cfg_t              cfg,
    input  wire logic                        advance,
    input  wire logic [asfd_pkg::BYTE_W-1:0] in_byte,
    output asfd_pkg::result_t                result
);

    // the oldest history byte is never compared after the shift, so only two are kept
    asfd_pkg::mode_t             mode_reg, mode_next;
    logic [asfd_pkg::BYTE_W-1:0] r1_reg, r1_next;
    logic [asfd_pkg::BYTE_W-1:0] r2_reg, r2_next;
    logic [asfd_pkg::BYTE_W-1:0] len_reg, len_next;
    logic [asfd_pkg::BYTE_W-1:0] idx_reg, idx_next;
    logic                        mine_reg, mine_next;
    logic [asfd_pkg::BYTE_W-1:0] idx_inc;
    logic                        at_end;
    logic                        addr_hit;

    assign idx_inc  = idx_reg + 8'd1;
    assign at_end   = idx_inc >= len_reg;
    assign addr_hit = (in_byte == cfg.device_address) || (in_byte == asfd_pkg::ADDR_BCAST)
                      || (cfg.forward_enable && (in_byte == cfg.forward_address));

    always_comb begin
        mode_next = mode_reg;
        r1_next   = r1_reg;
        r2_next   = r2_reg;
        len_next  = len_reg;
        idx_next  = idx_reg;
        mine_next = mine_reg;
        result    = '{valid: 1'b0, kind: asfd_pkg::KIND_PAYLOAD,
                      data: 8'd0, last: 1'b0, len: 8'd0};
        case (mode_reg)
            asfd_pkg::MODE_START: begin
                r1_next = r2_reg;
                r2_next = in_byte;
                if (r2_reg == asfd_pkg::CHAR_COLON && in_byte == asfd_pkg::CHAR_COLON) begin
                    // clear history so colons cannot feed an info pattern
                    r1_next   = 8'd0;
                    r2_next   = 8'd0;
                    mode_next = asfd_pkg::MODE_ADDR;
                end else if (r1_reg == asfd_pkg::CHAR_QMARK && r2_reg == asfd_pkg::CHAR_CR
                             && in_byte == asfd_pkg::CHAR_LF) begin
                    result.valid = 1'b1;
                    result.kind  = asfd_pkg::KIND_INFO;
                end
            end
            asfd_pkg::MODE_ADDR: begin
                mine_next = addr_hit;
                len_next  = 8'd0;
                mode_next = asfd_pkg::MODE_LEN;
            end
            asfd_pkg::MODE_LEN: begin
                if (in_byte < asfd_pkg::MIN_FRAME_LEN || in_byte > asfd_pkg::MAX_FRAME_LEN) begin
                    len_next  = 8'd0;
                    mine_next = 1'b0;
                    mode_next = asfd_pkg::MODE_START;
                end else begin
                    len_next  = in_byte;
                    idx_next  = 8'd0;
                    mode_next = mine_reg ? asfd_pkg::MODE_RECV : asfd_pkg::MODE_FOREIGN;
                end
            end
            asfd_pkg::MODE_RECV: begin
                idx_next     = idx_inc;
                result.valid = 1'b1;
                result.kind  = asfd_pkg::KIND_PAYLOAD;
                result.data  = in_byte;
                result.last  = at_end;
                result.len   = len_reg;
                if (at_end) begin
                    idx_next  = 8'd0;
                    len_next  = 8'd0;
                    mine_next = 1'b0;
                    mode_next = asfd_pkg::MODE_START;
                end
            end
            asfd_pkg::MODE_FOREIGN: begin
                idx_next = idx_inc;
                if (at_end) begin
                    idx_next     = 8'd0;
                    len_next     = 8'd0;
                    mine_next    = 1'b0;
                    mode_next    = asfd_pkg::MODE_START;
                    result.valid = 1'b1;
                    result.kind  = asfd_pkg::KIND_CTS;
                    result.len   = len_reg;
                end
            end
            default: begin
                mode_next = asfd_pkg::MODE_START;
            end
        endcase
        if (!advance) begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= asfd_pkg::MODE_START;
            r1_reg   <= 8'd0;
            r2_reg   <= 8'd0;
            len_reg  <= 8'd0;
            idx_reg  <= 8'd0;
            mine_reg <= 1'b0;
        end else if (advance) begin
            mode_reg <= mode_next;
            r1_reg   <= r1_next;
            r2_reg   <= r2_next;
            len_reg  <= len_next;
            idx_reg  <= idx_next;
            mine_reg <= mine_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/asfd_out_stage.sv @@
// result register that holds one event until the consumer takes it
`default_nettype none

module asfd_out_stage (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        advance,
    input  wire asfd_pkg::result_t           result,
    output wire logic                        m_valid,
    input  wire logic                        m_ready,
    output wire logic [1:0]                  m_event_kind,
    output wire logic [asfd_pkg::BYTE_W-1:0] m_payload_byte,
    output wire logic                        m_last_of_frame,
    output wire logic [asfd_pkg::BYTE_W-1:0] m_frame_length
);

    logic              valid_reg;
    logic              valid_next;
    asfd_pkg::result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            // advance implies the slot is empty or being drained
            valid_next = result.valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            data_reg <= result;
        end
    end

    assign m_valid         = valid_reg;
    assign m_event_kind    = data_reg.kind;
    assign m_payload_byte  = data_reg.data;
    assign m_last_of_frame = data_reg.last;
    assign m_frame_length  = data_reg.len;

endmodule

`default_nettype wire

@@ hdl/addressed_serial_frame_deframer.sv @@
// a byte passes the input register and the parser, and its result is registered in the output stage
// one byte per cycle while the output is not stalled; the parser is a single pass between two registers
// the input register takes a byte while a finished result waits on the output
// reset (aresetn low, synchronous): parser waits for start, history and counters zero,
// device_address 1, forward disabled, forward_address 0, both stages empty
`default_nettype none

`include "addressed_serial_frame_deframer_defines.svh"

module addressed_serial_frame_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output wire logic        s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output wire logic        m_valid,
    input  wire logic        m_ready,
    output wire logic [1:0]  m_event_kind,
    output wire logic [7:0]  m_payload_byte,
    output wire logic        m_last_of_frame,
    output wire logic [7:0]  m_frame_length,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);

    asfd_pkg::cfg_t              cfg;
    asfd_pkg::result_t           result;
    logic                        in_valid;
    logic [asfd_pkg::BYTE_W-1:0] in_byte;
    logic                        advance;

    // parser moves when a byte is held and the result slot is free or being drained
    assign advance = in_valid && (!m_valid || m_ready);

    asfd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    asfd_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    asfd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .in_byte (in_byte),
        .result  (result)
    );

    asfd_out_stage u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .result          (result),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_payload_byte  (m_payload_byte),
        .m_last_of_frame (m_last_of_frame),
        .m_frame_length  (m_frame_length)
    );

    `ASFD_ASSERT_NEXT(a_result_lands, advance && result.valid, m_valid, "result lost")
    `ASFD_ASSERT_NEXT(a_byte_held, in_valid && !advance, in_valid, "queued byte dropped")
    `ASFD_ASSERT_NOW(a_payload_len, m_valid && m_event_kind == asfd_pkg::KIND_PAYLOAD,
        m_frame_length >= asfd_pkg::MIN_FRAME_LEN && m_frame_length <= asfd_pkg::MAX_FRAME_LEN,
        "payload with bad frame length")
    `ASFD_ASSERT_NOW(a_info_clean, m_valid && m_event_kind == asfd_pkg::KIND_INFO,
        m_payload_byte == 8'd0 && m_frame_length == 8'd0 && !m_last_of_frame,
        "info event carries data")

endmodule

`default_nettype wire

@@ dv/tb_addressed_serial_frame_deframer.sv @@
// self-checking testbench for the addressed serial frame deframer
module tb_addressed_serial_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import asfd_pkg::*;

    localparam int unsigned N_PHASES        = 8;
    localparam int unsigned ITEMS_PER_PHASE = 140;
    localparam int unsigned HOLD_CYCLES     = 150;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned MAX_PRINTS      = 20;
    localparam logic [1:0]  CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
        logic [7:0] len;
    } deframe_evt_t;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_QUIET,
        CHK_GIVEN
    } row_chk_t;

    typedef struct {
        logic [7:0]   b;
        row_chk_t     chk;
        deframe_evt_t ev;
    } dir_row_t;

    localparam deframe_evt_t NO_EVT = '{KIND_PAYLOAD, 8'h00, 1'b0, 8'h00};
    localparam logic [7:0] CTRL_CHARS [4] = '{CHAR_COLON, CHAR_QMARK, CHAR_CR, CHAR_LF};

    localparam int DIR_N = 24;
    dir_row_t dir_tab [DIR_N] = '{
        '{CHAR_QMARK,    CHK_QUIET, NO_EVT},
        '{CHAR_CR,       CHK_QUIET, NO_EVT},
        '{CHAR_LF,       CHK_GIVEN, '{KIND_INFO, 8'h00, 1'b0, 8'h00}},
        '{CHAR_COLON,    CHK_QUIET, NO_EVT},
        '{CHAR_COLON,    CHK_QUIET, NO_EVT},
        '{8'h01,         CHK_QUIET, NO_EVT},      // reset device address
        '{MIN_FRAME_LEN, CHK_QUIET, NO_EVT},
        // colons inside a frame are plain payload
        '{CHAR_COLON,    CHK_GIVEN, '{KIND_PAYLOAD, CHAR_COLON, 1'b0, MIN_FRAME_LEN}},
        '{CHAR_COLON,    CHK_GIVEN, '{KIND_PAYLOAD, CHAR_COLON, 1'b1, MIN_FRAME_LEN}},
        // history was cleared at the start, so it takes two fresh colons again
        '{CHAR_COLON,    CHK_QUIET, NO_EVT},
        '{CHAR_COLON,    CHK_QUIET, NO_EVT},
        '{ADDR_BCAST,    CHK_QUIET, NO_EVT},
        '{8'h00,         CHK_QUIET, NO_EVT},      // zero length drops the frame
        '{CHAR_COLON,    CHK_QUIET, NO_EVT},
        '{CHAR_COLON,    CHK_QUIET, NO_EVT},
        '{8'hFF,         CHK_QUIET, NO_EVT},
        '{8'd129,        CHK_QUIET, NO_EVT},      // one above max length
        '{CHAR_COLON,    CHK_QUIET, NO_EVT},
        '{CHAR_COLON,    CHK_QUIET, NO_EVT},
        '{8'h80,         CHK_QUIET, NO_EVT},      // foreign address
        '{MIN_FRAME_LEN, CHK_QUIET, NO_EVT},
        '{CHAR_QMARK,    CHK_PREDICT, NO_EVT},
        '{CHAR_CR,       CHK_GIVEN, '{KIND_CTS, 8'h00, 1'b0, MIN_FRAME_LEN}},
        // info pattern split across a foreign frame must not fire
        '{CHAR_LF,       CHK_QUIET, NO_EVT}
    };

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte       = 8'h00;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic [1:0] m_event_kind;
    logic [7:0] m_payload_byte;
    logic       m_last_of_frame;
    logic [7:0] m_frame_length;
    logic       cfg_wr_en       = 1'b0;
    logic [1:0] cfg_index       = 2'd0;
    logic [7:0] cfg_wdata       = 8'h00;

    // predictor copy of the registers and parser state
    logic [7:0] my_addr  = 8'h01;
    logic       fwd_on   = 1'b0;
    logic [7:0] fwd_addr = 8'h00;
    mode_t      prs_mode = MODE_START;
    logic [7:0] hist [3] = '{default: 8'h00};
    logic [7:0] want_len = 8'h00;
    logic [7:0] frame_pos = 8'h00;
    logic       for_me   = 1'b0;

    deframe_evt_t pending_events [$];

    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_seq  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    int unsigned n_errors   = 0;
    int unsigned n_items    = 0;
    int unsigned n_payload  = 0;
    int unsigned n_info     = 0;
    int unsigned n_cts      = 0;
    int unsigned n_settings = 1;
    int unsigned n_in_stall = 0;

    addressed_serial_frame_deframer uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_payload_byte  (m_payload_byte),
        .m_last_of_frame (m_last_of_frame),
        .m_frame_length  (m_frame_length),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("%0t ns mismatch: %s", $realtime, what);
    endtask

    // one received byte through the parser; returns 1 when an event comes out
    function automatic bit deframe_step(input logic [7:0] b, output deframe_evt_t ev);
        bit fires;
        fires = 1'b0;
        ev = NO_EVT;
        case (prs_mode)
            MODE_START: begin
                hist[0] = hist[1];
                hist[1] = hist[2];
                hist[2] = b;
                if (hist[1] == CHAR_COLON && hist[2] == CHAR_COLON) begin
                    hist = '{default: 8'h00};
                    prs_mode = MODE_ADDR;
                end else if (hist[0] == CHAR_QMARK && hist[1] == CHAR_CR &&
                             hist[2] == CHAR_LF) begin
                    ev = '{KIND_INFO, 8'h00, 1'b0, 8'h00};
                    fires = 1'b1;
                end
            end
            MODE_ADDR: begin
                for_me = (b == my_addr) || (b == ADDR_BCAST) || (fwd_on && b == fwd_addr);
                want_len = 8'h00;
                prs_mode = MODE_LEN;
            end
            MODE_LEN: begin
                if (b < MIN_FRAME_LEN || b > MAX_FRAME_LEN) begin
                    want_len = 8'h00;
                    for_me = 1'b0;
                    prs_mode = MODE_START;
                end else begin
                    want_len = b;
                    frame_pos = 8'h00;
                    prs_mode = for_me ? MODE_RECV : MODE_FOREIGN;
                end
            end
            MODE_RECV, MODE_FOREIGN: begin
                frame_pos = frame_pos + 8'd1;
                if (prs_mode == MODE_RECV) begin
                    ev = '{KIND_PAYLOAD, b, frame_pos >= want_len, want_len};
                    fires = 1'b1;
                end else if (frame_pos >= want_len) begin
                    ev = '{KIND_CTS, 8'h00, 1'b0, want_len};
                    fires = 1'b1;
                end
                if (frame_pos >= want_len) begin
                    frame_pos = 8'h00;
                    want_len = 8'h00;
                    for_me = 1'b0;
                    prs_mode = MODE_START;
                end
            end
            default: prs_mode = MODE_START;
        endcase
        return fires;
    endfunction

    task automatic send_byte(input logic [7:0] b, input row_chk_t chk = CHK_PREDICT,
                             input deframe_evt_t given = NO_EVT);
        deframe_evt_t ev;
        bit fires;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        fires = deframe_step(b, ev);
        if (chk == CHK_GIVEN) begin
            fires = 1'b1;
            ev = given;
        end else if (chk == CHK_QUIET) begin
            fires = 1'b0;
        end
        if (fires)
            pending_events.push_back(ev);
        n_items++;
    endtask

    function automatic logic [7:0] line_byte();
        if ($urandom_range(7) == 0)
            return CTRL_CHARS[$urandom_range(3)];
        return 8'($urandom_range(255));
    endfunction

    // one random chunk of line traffic: mostly frames, some broken, info runs, noise
    task automatic send_unit();
        int unsigned pick;
        int unsigned n;
        logic [7:0] addr;
        logic [7:0] len;
        pick = $urandom_range(99);
        if (pick < 80) begin
            case ($urandom_range(4))
                0: addr = my_addr;
                1: addr = ADDR_BCAST;
                2: addr = fwd_addr;
                default: addr = 8'($urandom_range(255));
            endcase
            send_byte(CHAR_COLON);
            send_byte(CHAR_COLON);
            send_byte(addr);
            if (pick < 68) begin
                n = $urandom_range(99);
                if (n < 3)
                    len = MAX_FRAME_LEN;
                else if (n < 10)
                    len = 8'($urandom_range(MAX_FRAME_LEN, MIN_FRAME_LEN));
                else
                    len = 8'($urandom_range(12, MIN_FRAME_LEN));
                send_byte(len);
                repeat (len) send_byte(line_byte());
            end else begin
                case ($urandom_range(2))
                    0: len = 8'h00;
                    1: len = 8'h01;
                    default: len = 8'($urandom_range(255, 129));
                endcase
                send_byte(len);
            end
        end else if (pick < 90) begin
            send_byte(CHAR_QMARK);
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
        end else begin
            repeat ($urandom_range(4, 1)) send_byte(line_byte());
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_DEVICE_ADDRESS:  my_addr  = val;
            CFG_FORWARD_ENABLE:  fwd_on   = val[0];
            CFG_FORWARD_ADDRESS: fwd_addr = val;
            default: ;  // unused index, write is dropped
        endcase
    endtask

    // receiver: random stalls plus a long hold-off in the first phase
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        deframe_evt_t got;
        deframe_evt_t want;
        got = '{kind_t'(m_event_kind), m_payload_byte, m_last_of_frame, m_frame_length};
        if (aresetn && s_valid && !s_ready)
            n_in_stall++;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                flag_mismatch($sformatf("unexpected transaction kind %0d data %02h last %0b len %0d",
                                        m_event_kind, m_payload_byte, m_last_of_frame,
                                        m_frame_length));
            end else begin
                want = pending_events.pop_front();
                if (got !== want)
                    flag_mismatch($sformatf({"kind %0d/%0d data %02h/%02h last %0b/%0b ",
                                             "len %0d/%0d (got/want)"},
                                            got.kind, want.kind, got.data, want.data,
                                            got.last, want.last, got.len, want.len));
                case (want.kind)
                    KIND_PAYLOAD: n_payload++;
                    KIND_INFO:    n_info++;
                    default:      n_cts++;
                endcase
            end
        end
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned ph;
        int unsigned phase_base;
        logic [7:0] da;
        logic [7:0] fa;
        logic       fe;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 64; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 64; end
                default: begin src_idle_pct = 20; sink_stall_pct = 20; end
            endcase
            if (ph > 0) begin
                case (ph)
                    1: begin da = 8'hFF; fe = 1'b1; fa = 8'h00; end
                    2: begin da = 8'h00; fe = 1'b1; fa = 8'hFF; end
                    3: begin da = 8'h01; fe = 1'b0; fa = 8'hFF; end  // forward off, address set
                    default: begin
                        da = 8'($urandom_range(255));
                        fe = 1'($urandom_range(1));
                        fa = 8'($urandom_range(255));
                    end
                endcase
                write_reg(CFG_UNUSED_INDEX, 8'($urandom_range(255)));
                write_reg(CFG_DEVICE_ADDRESS, da);
                write_reg(CFG_FORWARD_ENABLE, {7'($urandom_range(127)), fe});
                write_reg(CFG_FORWARD_ADDRESS, fa);
                cfg_wr_en <= 1'b0;
                n_settings++;
            end else begin
                for (int r = 0; r < DIR_N; r++)
                    send_byte(dir_tab[r].b, dir_tab[r].chk, dir_tab[r].ev);
                // long receiver hold-off while a full-length frame keeps coming
                hold_seq++;
                send_byte(CHAR_COLON);
                send_byte(CHAR_COLON);
                send_byte(my_addr);
                send_byte(MAX_FRAME_LEN);
                repeat (MAX_FRAME_LEN) send_byte(8'($urandom_range(255)));
            end
            phase_base = n_items;
            while (n_items - phase_base < ITEMS_PER_PHASE)
                send_unit();
            s_valid <= 1'b0;
            while (pending_events.size() != 0)
                @(posedge aclk);
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end
        $display("run covered %0d byte transactions under %0d register settings, %0d input stall cycles",
                 n_items, n_settings, n_in_stall);
        $display("checked %0d payload, %0d info request and %0d clear-to-send transactions",
                 n_payload, n_info, n_cts);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/asfd_pkg.sv
hdl/asfd_cfg_regs.sv
hdl/asfd_in_stage.sv
hdl/asfd_parser.sv
hdl/asfd_out_stage.sv
hdl/addressed_serial_frame_deframer.sv
dv/tb_addressed_serial_frame_deframer.sv
